/* sv/teadf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trace event allow/deny filter package
// Depths, entry and beat types, opcodes and the entry match function.
// ----------------------------------------------------------------------------
package teadf_pkg;

  localparam int unsigned ALLOW_DEPTH = 16;
  localparam int unsigned DENY_DEPTH  = 16;
  localparam int unsigned MAX_DEPTH   = (ALLOW_DEPTH > DENY_DEPTH) ? ALLOW_DEPTH : DENY_DEPTH;

  localparam int unsigned ALLOW_CW = $clog2(ALLOW_DEPTH + 1);
  localparam int unsigned DENY_CW  = $clog2(DENY_DEPTH + 1);
  localparam int unsigned SCAN_W   = $clog2(MAX_DEPTH + 1);
  localparam int unsigned ALLOW_AW = (ALLOW_DEPTH > 1) ? $clog2(ALLOW_DEPTH) : 1;
  localparam int unsigned DENY_AW  = (DENY_DEPTH > 1) ? $clog2(DENY_DEPTH) : 1;

  localparam logic [9:0] FAULT_CODE_RESET = 10'd11;

  typedef enum logic [1:0] {
    OP_ADD_ALLOW = 2'd0,
    OP_ADD_DENY  = 2'd1,
    OP_CHECK     = 2'd2,
    OP_NONE      = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_TERMINATED = 3'd0,
    KIND_EXITED     = 3'd1,
    KIND_SIGNAL     = 3'd2,
    KIND_SYSCALL    = 3'd3,
    KIND_USER       = 3'd4
  } kind_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [2:0] event_kind;
    logic [9:0] event_code;
    logic       at_entry;
  } req_t;

  typedef struct packed {
    logic passes;
    logic halts_process;
    logic list_full;
  } rsp_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [9:0] code;
    logic       flag;
  } entry_t;

  function automatic logic entry_match(entry_t ent, entry_t evt);
    logic kind_ok;
    logic code_ok;
    logic flag_ok;
    kind_ok = (ent.kind == evt.kind);
    code_ok = (ent.code == 10'd0) || (ent.code == evt.code);
    flag_ok = (evt.kind != KIND_SYSCALL) || (ent.flag == evt.flag);
    return kind_ok && code_ok && flag_ok;
  endfunction

endpackage

/* sv/trace_event_allow_deny_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trace event allow/deny filter
// Allow and deny tables in two synchronous RAMs; a check scans both in step.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                 Beat
// in       input      in_valid_i / in_ready_o   teadf_pkg::req_t
// out      output     out_valid_o / out_ready_i teadf_pkg::rsp_t
// cfg      input      cfg_we_i                  fault signal code, 10 bits
//
// Insert, or a check with both tables empty: the result goes from the done
//   state into the output register; the next beat is accepted back in idle.
// Check: both tables are scanned over max(allow count, deny count) entries,
//   then the result goes through the done state as above; both tables are read one
//   entry per cycle through their single read ports, side by side.
// Reset clears both counts and sets the fault code to 11; no clearing pass.
// A result waiting on out_ready_i does not block the next accept; a second
//   finished result waits in the done state until the output register frees.
// ----------------------------------------------------------------------------
module trace_event_allow_deny_filter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  teadf_pkg::req_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output teadf_pkg::rsp_t   out_data_o,
  input  logic              cfg_we_i,
  input  logic [9:0]        cfg_wdata_i
);
  import teadf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic [9:0]           fault_code_q;
  logic [ALLOW_CW-1:0]  allow_cnt_q, allow_cnt_d;
  logic [DENY_CW-1:0]   deny_cnt_q, deny_cnt_d;
  logic [SCAN_W-1:0]    idx_q, idx_d;
  logic [SCAN_W-1:0]    len_q, len_d;
  entry_t               evt_q, evt_d;
  logic                 allow_hit_q, allow_hit_d;
  logic                 deny_hit_q, deny_hit_d;
  logic                 halts_q, halts_d;
  logic                 rva_q, rvd_q, rlast_q;
  logic                 rva_d, rvd_d, rlast_d;
  rsp_t                 res_q, res_d;
  logic                 out_valid_q, out_valid_d;
  rsp_t                 out_data_q;
  logic                 out_load;

  entry_t               allow_mem [ALLOW_DEPTH];
  entry_t               deny_mem [DENY_DEPTH];
  entry_t               allow_rd_q, deny_rd_q;
  logic                 allow_we, deny_we;
  entry_t               new_ent;
  logic                 issue;
  logic                 accept;
  logic [SCAN_W-1:0]    allow_len, deny_len;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign new_ent.kind = in_data_i.event_kind;
  assign new_ent.code = in_data_i.event_code;
  assign new_ent.flag = in_data_i.at_entry;

  assign allow_len = SCAN_W'(allow_cnt_q);
  assign deny_len  = SCAN_W'(deny_cnt_q);
  assign issue     = (state_q == ST_SCAN) && (idx_q != len_q);

  always_comb begin
    state_d     = state_q;
    allow_cnt_d = allow_cnt_q;
    deny_cnt_d  = deny_cnt_q;
    idx_d       = idx_q;
    len_d       = len_q;
    evt_d       = evt_q;
    allow_hit_d = allow_hit_q;
    deny_hit_d  = deny_hit_q;
    halts_d     = halts_q;
    res_d       = res_q;
    allow_we    = 1'b0;
    deny_we     = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    rva_d       = issue && (idx_q < allow_len);
    rvd_d       = issue && (idx_q < deny_len);
    rlast_d     = issue && ((idx_q + SCAN_W'(1)) == len_q);

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d   = '0;
          state_d = ST_DONE;
          case (op_e'(in_data_i.operation))
            OP_ADD_ALLOW: begin
              if (allow_cnt_q < ALLOW_CW'(ALLOW_DEPTH)) begin
                allow_we    = 1'b1;
                allow_cnt_d = allow_cnt_q + ALLOW_CW'(1);
              end else begin
                res_d.list_full = 1'b1;
              end
            end
            OP_ADD_DENY: begin
              if (deny_cnt_q < DENY_CW'(DENY_DEPTH)) begin
                deny_we    = 1'b1;
                deny_cnt_d = deny_cnt_q + DENY_CW'(1);
              end else begin
                res_d.list_full = 1'b1;
              end
            end
            OP_CHECK: begin
              evt_d       = new_ent;
              allow_hit_d = (allow_cnt_q == '0);
              deny_hit_d  = 1'b0;
              halts_d     = (in_data_i.event_kind == KIND_EXITED) ||
                            (in_data_i.event_kind == KIND_TERMINATED) ||
                            ((in_data_i.event_kind == KIND_SIGNAL) &&
                             (in_data_i.event_code == fault_code_q));
              idx_d       = '0;
              len_d       = (allow_len > deny_len) ? allow_len : deny_len;
              if ((allow_len != '0) || (deny_len != '0)) begin
                state_d = ST_SCAN;
              end else begin
                res_d.passes        = 1'b1;
                res_d.halts_process = halts_d;
              end
            end
            default: begin
              res_d = '0;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (issue) begin
          idx_d = idx_q + SCAN_W'(1);
        end
        allow_hit_d = allow_hit_q || (rva_q && entry_match(allow_rd_q, evt_q));
        deny_hit_d  = deny_hit_q || (rvd_q && entry_match(deny_rd_q, evt_q));
        if (rlast_q) begin
          res_d.passes        = allow_hit_d && !deny_hit_d;
          res_d.halts_process = halts_q;
          res_d.list_full     = 1'b0;
          state_d             = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (allow_we) begin
      allow_mem[allow_cnt_q[ALLOW_AW-1:0]] <= new_ent;
    end
    if (issue) begin
      allow_rd_q <= allow_mem[idx_q[ALLOW_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (deny_we) begin
      deny_mem[deny_cnt_q[DENY_AW-1:0]] <= new_ent;
    end
    if (issue) begin
      deny_rd_q <= deny_mem[idx_q[DENY_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      fault_code_q <= FAULT_CODE_RESET;
      allow_cnt_q  <= '0;
      deny_cnt_q   <= '0;
      rva_q        <= 1'b0;
      rvd_q        <= 1'b0;
      rlast_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      allow_cnt_q <= allow_cnt_d;
      deny_cnt_q  <= deny_cnt_d;
      rva_q       <= rva_d;
      rvd_q       <= rvd_d;
      rlast_q     <= rlast_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        fault_code_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    len_q       <= len_d;
    evt_q       <= evt_d;
    allow_hit_q <= allow_hit_d;
    deny_hit_q  <= deny_hit_d;
    halts_q     <= halts_d;
    res_q       <= res_d;
    if (out_load) begin
      out_data_q <= res_q;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (allow_cnt_q <= ALLOW_CW'(ALLOW_DEPTH)) && (deny_cnt_q <= DENY_CW'(DENY_DEPTH)))
    else $error("table count beyond depth");

  a_rd_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rva_q || rvd_q || rlast_q) |-> (state_q == ST_SCAN))
    else $error("read data tagged outside a scan");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_data_i.operation == OP_ADD_ALLOW) &&
     (allow_cnt_q == ALLOW_CW'(ALLOW_DEPTH)))
    |=> (res_q.list_full && $stable(allow_cnt_q)))
    else $error("insert into full allow table not rejected");
`endif

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the trace event allow/deny filter
// Drives insert and check requests through bursty valid/ready traffic while
// the response side stalls on its own pattern, predicts every response beat
// from a scoreboard copy of both tables and the fault code, and compares the
// beats field by field. The fault code moves through several values,
// extremes included, between idle phases.
// ----------------------------------------------------------------------------
module tb_top;
  import teadf_pkg::*;

  localparam logic [2:0] KIND_UNKNOWN_A = 3'd5;
  localparam logic [2:0] KIND_UNKNOWN_B = 3'd6;
  localparam logic [2:0] KIND_UNKNOWN_C = 3'd7;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  req_t       in_data_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  rsp_t       out_data_o;
  logic       cfg_we_i    = 1'b0;
  logic [9:0] cfg_wdata_i = '0;

  trace_event_allow_deny_filter u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1000000;
    $display("trace_event_allow_deny_filter test failed");
    $finish;
  end

  // scoreboard copy of the filter state
  entry_t      permit_tab [ALLOW_DEPTH];
  entry_t      block_tab  [DENY_DEPTH];
  int unsigned permit_cnt = 0;
  int unsigned block_cnt  = 0;
  logic [9:0]  fault_sig  = FAULT_CODE_RESET;

  req_t        req_backlog [$];
  rsp_t        verdicts_due [$];
  entry_t      entry_pool [$];
  int unsigned planned_permit = 0;
  int unsigned planned_block  = 0;

  logic        no_idle = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned items_taken = 0;
  int unsigned checks_taken = 0;
  int unsigned passes_seen = 0;
  int unsigned halts_seen = 0;
  int unsigned full_seen = 0;
  int unsigned fault_settings = 1;

  function automatic logic entry_hit(entry_t ent, req_t r);
    if (ent.kind != r.event_kind) return 1'b0;
    if (ent.code != '0 && ent.code != r.event_code) return 1'b0;
    if (r.event_kind == KIND_SYSCALL && ent.flag != r.at_entry) return 1'b0;
    return 1'b1;
  endfunction

  function automatic rsp_t filter_outcome(req_t r);
    rsp_t res;
    logic allowed;
    logic denied;
    int   i;
    res = '0;
    case (r.operation)
      OP_ADD_ALLOW: begin
        if (permit_cnt < ALLOW_DEPTH) begin
          permit_tab[permit_cnt] = {r.event_kind, r.event_code, r.at_entry};
          permit_cnt++;
        end else begin
          res.list_full = 1'b1;
        end
      end
      OP_ADD_DENY: begin
        if (block_cnt < DENY_DEPTH) begin
          block_tab[block_cnt] = {r.event_kind, r.event_code, r.at_entry};
          block_cnt++;
        end else begin
          res.list_full = 1'b1;
        end
      end
      OP_CHECK: begin
        allowed = (permit_cnt == 0);
        denied  = 1'b0;
        for (i = 0; i < int'(permit_cnt); i++) begin
          if (entry_hit(permit_tab[i], r)) allowed = 1'b1;
        end
        for (i = 0; i < int'(block_cnt); i++) begin
          if (entry_hit(block_tab[i], r)) denied = 1'b1;
        end
        res.passes        = allowed && !denied;
        res.halts_process = (r.event_kind == KIND_EXITED) ||
                            (r.event_kind == KIND_TERMINATED) ||
                            (r.event_kind == KIND_SIGNAL && r.event_code == fault_sig);
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 30) $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic queue_item(input op_e op, input logic [2:0] kind,
                            input logic [9:0] code, input logic flag);
    req_t   r;
    entry_t ent;
    r.operation  = op;
    r.event_kind = kind;
    r.event_code = code;
    r.at_entry   = flag;
    ent          = {kind, code, flag};
    req_backlog  = {req_backlog, r};
    if (op == OP_ADD_ALLOW && planned_permit < ALLOW_DEPTH) begin
      planned_permit++;
      entry_pool = {entry_pool, ent};
    end
    if (op == OP_ADD_DENY && planned_block < DENY_DEPTH) begin
      planned_block++;
      entry_pool = {entry_pool, ent};
    end
  endtask

  task automatic queue_random_item();
    int unsigned roll;
    op_e         op;
    logic [2:0]  kind;
    logic [9:0]  code;
    logic        flag;
    entry_t      pick;
    logic        filling;
    filling = (planned_permit < ALLOW_DEPTH) || (planned_block < DENY_DEPTH);
    kind = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(KIND_UNKNOWN_A, KIND_UNKNOWN_C))
                                       : 3'($urandom_range(KIND_TERMINATED, KIND_USER));
    code = 10'($urandom);
    flag = 1'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      op = OP_NONE;
    end else if (roll < (filling ? 14 : 6)) begin
      op = ($urandom_range(0, 1) == 0) ? OP_ADD_ALLOW : OP_ADD_DENY;
      roll = $urandom_range(0, 9);
      if (roll < 3) code = '0;
      else if (roll < 7) code = 10'($urandom_range(1, 15));
    end else begin
      op = OP_CHECK;
      roll = $urandom_range(0, 9);
      if (roll < 5 && entry_pool.size() != 0) begin
        pick = entry_pool[$urandom_range(0, entry_pool.size() - 1)];
        kind = pick.kind;
        if (pick.code != '0) code = pick.code;
        flag = ($urandom_range(0, 3) == 0) ? ~pick.flag : pick.flag;
      end else if (roll == 5) begin
        kind = KIND_SIGNAL;
        code = fault_sig;
      end else if (roll == 6) begin
        code = '0;
      end else if (roll == 7) begin
        code = 10'($urandom_range(1, 15));
      end
    end
    queue_item(op, kind, code, flag);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (req_backlog.size() != 0 || in_valid_i || verdicts_due.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_fault_code(input logic [9:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    fault_sig   = value;
    fault_settings++;
    @(negedge clk_i);
  endtask

  // request driver: bursts of random length separated by random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        verdicts_due = {verdicts_due, filter_outcome(in_data_i)};
        items_taken++;
        if (in_data_i.operation == OP_CHECK) checks_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0 && !no_idle) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          in_data_i  <= req_backlog.pop_front();
          in_valid_i <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 20);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // response side: stall modes plus occasional long hold-offs
  int unsigned rcv_beats    = 0;
  int unsigned next_hold_at = 150;
  int unsigned hold_left    = 0;
  int unsigned mode_left    = 0;
  int unsigned rcv_tick     = 0;
  int unsigned rcv_mode     = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      rcv_tick++;
      if (out_valid_o && out_ready_i) rcv_beats++;
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (rcv_beats >= next_hold_at) begin
        hold_left    = 250;
        next_hold_at = next_hold_at + 750;
        out_ready_i <= 1'b0;
      end else if (no_idle) begin
        out_ready_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          rcv_mode  = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 80);
        end else begin
          mode_left--;
        end
        case (rcv_mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom);
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= ((rcv_tick % 5) < 2);
        endcase
      end
    end
  end

  // response checker
  rsp_t want;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (verdicts_due.size() == 0) begin
        report_mismatch($sformatf("response beat %b with none pending", out_data_o));
      end else begin
        want = verdicts_due.pop_front();
        if (out_data_o.passes !== want.passes)
          report_mismatch($sformatf("passes %b, want %b", out_data_o.passes, want.passes));
        if (out_data_o.halts_process !== want.halts_process)
          report_mismatch($sformatf("halts_process %b, want %b",
                                    out_data_o.halts_process, want.halts_process));
        if (out_data_o.list_full !== want.list_full)
          report_mismatch($sformatf("list_full %b, want %b",
                                    out_data_o.list_full, want.list_full));
        passes_seen += want.passes;
        halts_seen  += want.halts_process;
        full_seen   += want.list_full;
      end
    end
  end

  initial begin
    logic [9:0] fault_steps [4];
    int         ph;
    int         n;
    fault_steps[0] = 10'd1023;
    fault_steps[1] = 10'd0;
    fault_steps[2] = 10'($urandom_range(1, 1022));
    fault_steps[3] = FAULT_CODE_RESET;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty tables, reset fault code
    queue_item(OP_CHECK, KIND_TERMINATED, 10'd0, 1'b0);
    queue_item(OP_CHECK, KIND_EXITED, 10'd1023, 1'b1);
    queue_item(OP_CHECK, KIND_SIGNAL, FAULT_CODE_RESET, 1'b0);
    queue_item(OP_CHECK, KIND_SIGNAL, 10'd10, 1'b1);
    queue_item(OP_CHECK, KIND_SYSCALL, 10'd1023, 1'b1);
    queue_item(OP_CHECK, KIND_USER, 10'h2AA, 1'b0);
    queue_item(OP_CHECK, KIND_UNKNOWN_C, 10'h155, 1'b1);
    queue_item(OP_NONE, KIND_UNKNOWN_C, 10'h3FF, 1'b1);
    queue_item(OP_NONE, KIND_TERMINATED, 10'd0, 1'b0);
    // deny only: flag matters for syscalls alone
    queue_item(OP_ADD_DENY, KIND_SYSCALL, 10'd59, 1'b1);
    queue_item(OP_CHECK, KIND_SYSCALL, 10'd59, 1'b1);
    queue_item(OP_CHECK, KIND_SYSCALL, 10'd59, 1'b0);
    queue_item(OP_ADD_DENY, KIND_UNKNOWN_A, 10'd0, 1'b1);
    queue_item(OP_CHECK, KIND_UNKNOWN_A, 10'd1023, 1'b0);
    queue_item(OP_CHECK, KIND_UNKNOWN_B, 10'd1023, 1'b0);
    // allow list becomes non-empty
    queue_item(OP_ADD_ALLOW, KIND_USER, 10'd0, 1'b0);
    queue_item(OP_CHECK, KIND_USER, 10'd1, 1'b1);
    queue_item(OP_CHECK, KIND_SYSCALL, 10'd60, 1'b1);
    queue_item(OP_ADD_ALLOW, KIND_UNKNOWN_B, 10'd1023, 1'b1);
    queue_item(OP_CHECK, KIND_UNKNOWN_B, 10'd1023, 1'b0);
    queue_item(OP_CHECK, KIND_UNKNOWN_B, 10'd1022, 1'b1);
    queue_item(OP_CHECK, KIND_SIGNAL, FAULT_CODE_RESET, 1'b1);
    wait_idle();

    for (ph = 0; ph < 4; ph++) begin
      write_fault_code(fault_steps[ph]);
      no_idle = (ph == 2);
      for (n = 0; n < 308; n++) queue_random_item();
      wait_idle();
    end
    no_idle = 1'b0;

    repeat (40) @(negedge clk_i);
    $display("Covered %0d requests (%0d checks) across %0d fault code settings.",
             items_taken, checks_taken, fault_settings);
    $display("Events passed: %0d, process halted: %0d, inserts refused on full list: %0d.",
             passes_seen, halts_seen, full_seen);
    if (mismatch_count == 0) begin
      $display("trace_event_allow_deny_filter test passed");
    end else begin
      $display("trace_event_allow_deny_filter test failed");
    end
    $finish;
  end

endmodule

/* files.f */
sv/teadf_pkg.sv
sv/trace_event_allow_deny_filter.sv
bench/tb_top.sv
